// ===== src/ogi_pkg.sv =====
`timescale 1ns / 1ps

package ogi_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 16;

    localparam int POS_W      = 27;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 16;
    localparam int CFG_RAD_W  = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS     = 2'd2;

    localparam logic [CFG_WID_W-1:0] MAP_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_HGT_W-1:0] MAP_HEIGHT_RST = 16'd1024;
    localparam logic [CFG_RAD_W-1:0] RADIUS_RST     = 5'd8;

    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        CLS_UNKNOWN  = 2'd0,
        CLS_FREE     = 2'd1,
        CLS_INFLATED = 2'd2,
        CLS_WALL     = 2'd3
    } cls_t;

    // centre cell travelling alongside the window
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] out_col;
        cls_t                 cls;
    } info_t;

    typedef struct packed {
        logic valid;
        logic push;
    } s1_ctl_t;

endpackage

// ===== src/ogi_if.sv =====
`timescale 1ns / 1ps

interface ogi_cell_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] cell_class;

    modport source (output valid, output cmd, output cell_class, input ready);
    modport sink (input valid, input cmd, input cell_class, output ready);
endinterface

interface ogi_cell_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_class;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        last_cell;

    modport source (output valid, output out_class, output out_row, output out_col,
                    output last_cell, input ready);
    modport sink (input valid, input out_class, input out_row, input out_col,
                  input last_cell, output ready);
endinterface

interface ogi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== src/ogi_window.sv =====
`timescale 1ns / 1ps

module ogi_window #(
    parameter int MAX_WIDTH  = ogi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = ogi_pkg::MAX_RADIUS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  ogi_pkg::s1_ctl_t                    s1_ctl,
    input  logic [$clog2(2*MAX_RADIUS)-1:0]     s1_base,
    input  logic [2*MAX_RADIUS-1:0]             s1_word,
    input  ogi_pkg::info_t                      s1_info,
    input  logic [$clog2(MAX_WIDTH)-1:0]        s1_col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff,
    input  logic [ogi_pkg::ROW_W-1:0]           h_eff,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]     r_eff,
    input  logic [2*MAX_RADIUS-2:0][2*MAX_RADIUS-2:0] disk,
    output logic                                s3_valid,
    output ogi_pkg::info_t                      s3_info,
    output logic [2*MAX_RADIUS-2:0]             s3_hit
);

    localparam int RING   = 2 * MAX_RADIUS;
    localparam int RING_W = $clog2(RING);
    localparam int TAPS   = RING - 1;
    localparam int WC_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROWK_W = ogi_pkg::ROW_W + RING_W + 1;
    localparam int CK_W   = WC_W + RING_W + 1;

    logic [TAPS-1:0] tap_reg [TAPS];
    logic [TAPS-1:0] aligned;
    logic [TAPS-1:0] rowmask_next, rowmask_reg;
    logic [TAPS-1:0] colok_next, colok_reg;
    logic [TAPS-1:0] hit_next, hit_reg;
    logic            s2_valid_reg, s3_valid_reg;
    ogi_pkg::info_t  s2_info_reg, s3_info_reg;

    // align the column word so that bit k is row (centre - radius + 1 + k)
    always_comb
    begin
        logic [RING_W:0] idx;
        for (int k = 0; k < TAPS; k++)
        begin
            idx = (RING_W+1)'(s1_base) + (RING_W+1)'(k);
            if (idx >= (RING_W+1)'(RING))
            begin
                idx = idx - (RING_W+1)'(RING);
            end
            aligned[k] = s1_word[idx[RING_W-1:0]];
        end
    end

    always_comb
    begin
        logic [ROWK_W-1:0] rk;
        logic [ROWK_W-1:0] hr;
        logic [CK_W-1:0]   cs;
        hr = ROWK_W'(h_eff) + ROWK_W'(r_eff);
        cs = CK_W'(s1_col) + CK_W'(r_eff);
        for (int k = 0; k < TAPS; k++)
        begin
            rk = ROWK_W'(s1_info.row) + ROWK_W'(k + 1);
            rowmask_next[k] = (rk >= ROWK_W'(r_eff)) && (rk < hr);
        end
        for (int j = 0; j < TAPS; j++)
        begin
            colok_next[j] = (cs >= CK_W'(j + 1)) && (cs < CK_W'(w_eff) + CK_W'(j + 1));
        end
    end

    // shift line of aligned columns, newest at tap 0
    always_ff @(posedge clk)
    begin
        if (adv && s1_ctl.valid && s1_ctl.push)
        begin
            tap_reg[0] <= aligned;
            for (int j = 1; j < TAPS; j++)
            begin
                tap_reg[j] <= tap_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            hit_next[j] = colok_reg[j] & (|(tap_reg[j] & rowmask_reg & disk[j]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_ctl.valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_info_reg <= s1_info;
            rowmask_reg <= rowmask_next;
            colok_reg   <= colok_next;
            s3_info_reg <= s2_info_reg;
            hit_reg     <= hit_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_info  = s3_info_reg;
    assign s3_hit   = hit_reg;

endmodule

// ===== src/occupancy_grid_inflation.sv =====
`timescale 1ns / 1ps

// channel   dir  word
// cell_in   in   cmd, cell_class
// cell_out  out  out_class, out_row, out_col, last_cell
// cfg       in   addr (0 map_width, 1 map_height, 2 radius), data
//
// One word per cycle in and out. Between taking the word that releases a result
// and presenting it, the line store read, the column alignment, the window test
// and the output register each hold one stage. Results trail the input by radius
// rows plus radius columns. A config write, and reset, hold cell_in while the
// derived terms settle. Reset clears the counters and the valid flags and loads
// the config defaults; the line store is not cleared. A stall on cell_out holds
// every stage.
module occupancy_grid_inflation #(
    parameter int MAX_WIDTH  = ogi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = ogi_pkg::MAX_RADIUS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ogi_cell_in_if.sink    cell_in,
    ogi_cell_out_if.source cell_out,
    ogi_cfg_if.sink        cfg
);

    localparam int RING   = 2 * MAX_RADIUS;
    localparam int RING_W = $clog2(RING);
    localparam int TAPS   = RING - 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WC_W   = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int POS_W  = ogi_pkg::POS_W;
    localparam int ROW_W  = ogi_pkg::ROW_W;
    localparam int PROD_W = WC_W + ROW_W;
    localparam int RW_W   = WC_W + RAD_W;
    localparam int SQ_W   = $clog2(8 * MAX_RADIUS * MAX_RADIUS + 1);

    // configuration
    logic [ogi_pkg::CFG_WID_W-1:0] map_width_reg;
    logic [ogi_pkg::CFG_HGT_W-1:0] map_height_reg;
    logic [ogi_pkg::CFG_RAD_W-1:0] radius_reg;
    logic [1:0]                    busy_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= ogi_pkg::MAP_WIDTH_RST;
            map_height_reg <= ogi_pkg::MAP_HEIGHT_RST;
            radius_reg     <= ogi_pkg::RADIUS_RST;
            busy_reg       <= 2'd3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                ogi_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg.data[ogi_pkg::CFG_WID_W-1:0];
                ogi_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg.data[ogi_pkg::CFG_HGT_W-1:0];
                ogi_pkg::REG_RADIUS:     radius_reg     <= cfg.data[ogi_pkg::CFG_RAD_W-1:0];
                default: ;
            endcase
            busy_reg <= 2'd3;
        end
        else if (busy_reg != 2'd0)
        begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    // derived terms, three register steps
    logic [WC_W-1:0]           w_eff_next, w_eff_reg;
    logic [ROW_W-1:0]          h_eff_next, h_eff_reg;
    logic [RAD_W-1:0]          r_eff_next, r_eff_reg;
    logic [PROD_W-1:0]         wh_prod;
    logic [RW_W-1:0]           rw_prod, rw_reg;
    logic [POS_W-1:0]          total_reg, lag_next, lag_reg, rdstart_reg, end_reg;
    logic [SQ_W-1:0]           dsq_next [TAPS];
    logic [SQ_W-1:0]           dsq_reg  [TAPS];
    logic [SQ_W-1:0]           rsq;
    logic [TAPS-1:0][TAPS-1:0] disk_next, disk_reg;

    always_comb
    begin
        if (map_width_reg == '0)
        begin
            w_eff_next = WC_W'(1);
        end
        else if (map_width_reg > MAX_WIDTH)
        begin
            w_eff_next = WC_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff_next = WC_W'(map_width_reg);
        end
        h_eff_next = (map_height_reg == '0) ? ROW_W'(1) : map_height_reg;
        r_eff_next = (radius_reg > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
    end

    assign wh_prod = PROD_W'(w_eff_reg) * PROD_W'(h_eff_reg);
    assign rw_prod = RW_W'(w_eff_reg) * RW_W'(r_eff_reg);
    assign lag_next = POS_W'(rw_reg) + POS_W'(r_eff_reg);
    assign rsq = SQ_W'(r_eff_reg) * SQ_W'(r_eff_reg);

    always_comb
    begin
        logic [RING_W-1:0] d;
        for (int j = 0; j < TAPS; j++)
        begin
            if (j + 1 >= r_eff_reg)
            begin
                d = RING_W'(j + 1 - r_eff_reg);
            end
            else
            begin
                d = RING_W'(r_eff_reg - 1 - j);
            end
            dsq_next[j] = SQ_W'(d) * SQ_W'(d);
        end
        for (int j = 0; j < TAPS; j++)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                disk_next[j][k] = (dsq_reg[j] + dsq_reg[k]) < rsq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_eff_reg   <= w_eff_next;
        h_eff_reg   <= h_eff_next;
        r_eff_reg   <= r_eff_next;
        total_reg   <= POS_W'(wh_prod);
        rw_reg      <= rw_prod;
        dsq_reg     <= dsq_next;
        lag_reg     <= lag_next;
        rdstart_reg <= POS_W'(rw_reg) + POS_W'(1);
        end_reg     <= total_reg + lag_next;
        disk_reg    <= disk_next;
    end

    // stream position and the three raster counters
    logic                out_valid_reg;
    logic                adv;
    logic                accept;
    logic [POS_W-1:0]    p_reg, p_cur, p_next;
    logic [COL_W-1:0]    in_col_reg, in_col_cur, in_col_next;
    logic [RING_W-1:0]   in_ring_reg, in_ring_cur, in_ring_next;
    logic [COL_W-1:0]    rd_col_reg, rd_col_cur, rd_col_next;
    logic [RING_W-1:0]   rd_ring_reg, rd_ring_cur, rd_ring_next;
    logic [ROW_W-1:0]    c_row_reg, c_row_cur, c_row_next;
    logic [COL_W-1:0]    c_col_reg, c_col_cur, c_col_next;
    logic [RING_W-1:0]   c_ring_reg, c_ring_cur, c_ring_next;
    logic                restart, in_map, drop, rd_en, emit, last, wr_en;
    logic [RING_W+1:0]   bsum;
    logic [RING_W-1:0]   base;
    logic [RAD_W-1:0]    rb;

    assign adv          = !out_valid_reg || cell_out.ready;
    assign cell_in.ready = adv && (busy_reg == 2'd0);
    assign accept       = cell_in.valid && cell_in.ready;

    always_comb
    begin
        restart     = p_reg >= end_reg;
        p_cur       = restart ? '0 : p_reg;
        in_col_cur  = restart ? '0 : in_col_reg;
        in_ring_cur = restart ? '0 : in_ring_reg;
        rd_col_cur  = restart ? '0 : rd_col_reg;
        rd_ring_cur = restart ? '0 : rd_ring_reg;
        c_row_cur   = restart ? '0 : c_row_reg;
        c_col_cur   = restart ? '0 : c_col_reg;
        c_ring_cur  = restart ? '0 : c_ring_reg;

        in_map = p_cur < total_reg;
        // a flush while map cells are still due is dropped
        drop   = in_map && (cell_in.cmd == ogi_pkg::CMD_FLUSH);
        rd_en  = !drop && (p_cur >= rdstart_reg);
        emit   = !drop && (p_cur >= lag_reg);
        last   = emit && (c_row_cur == h_eff_reg - ROW_W'(1))
                      && (WC_W'(c_col_cur) + WC_W'(1) == w_eff_reg);
        wr_en  = accept && in_map && !drop;

        rb   = (r_eff_reg == '0) ? RAD_W'(1) : r_eff_reg;
        bsum = (RING_W+2)'(rd_ring_cur) + (RING_W+2)'(RING + 1) - (RING_W+2)'(rb);
        if (bsum >= (RING_W+2)'(RING))
        begin
            bsum = bsum - (RING_W+2)'(RING);
        end
        base = bsum[RING_W-1:0];

        p_next       = p_reg;
        in_col_next  = in_col_reg;
        in_ring_next = in_ring_reg;
        rd_col_next  = rd_col_reg;
        rd_ring_next = rd_ring_reg;
        c_row_next   = c_row_reg;
        c_col_next   = c_col_reg;
        c_ring_next  = c_ring_reg;

        if (accept)
        begin
            p_next       = p_cur;
            in_col_next  = in_col_cur;
            in_ring_next = in_ring_cur;
            rd_col_next  = rd_col_cur;
            rd_ring_next = rd_ring_cur;
            c_row_next   = c_row_cur;
            c_col_next   = c_col_cur;
            c_ring_next  = c_ring_cur;
            if (!drop)
            begin
                p_next = p_cur + POS_W'(1);
                if (in_map)
                begin
                    if (WC_W'(in_col_cur) + WC_W'(1) == w_eff_reg)
                    begin
                        in_col_next  = '0;
                        in_ring_next = (in_ring_cur == RING_W'(RING - 1)) ? '0
                                       : in_ring_cur + RING_W'(1);
                    end
                    else
                    begin
                        in_col_next = in_col_cur + COL_W'(1);
                    end
                end
                if (rd_en)
                begin
                    if (WC_W'(rd_col_cur) + WC_W'(1) == w_eff_reg)
                    begin
                        rd_col_next  = '0;
                        rd_ring_next = (rd_ring_cur == RING_W'(RING - 1)) ? '0
                                       : rd_ring_cur + RING_W'(1);
                    end
                    else
                    begin
                        rd_col_next = rd_col_cur + COL_W'(1);
                    end
                end
                if (emit)
                begin
                    if (WC_W'(c_col_cur) + WC_W'(1) == w_eff_reg)
                    begin
                        c_col_next  = '0;
                        c_row_next  = c_row_cur + ROW_W'(1);
                        c_ring_next = (c_ring_cur == RING_W'(RING - 1)) ? '0
                                      : c_ring_cur + RING_W'(1);
                    end
                    else
                    begin
                        c_col_next = c_col_cur + COL_W'(1);
                    end
                end
                // final cell out: start a new map
                if (last)
                begin
                    p_next       = '0;
                    in_col_next  = '0;
                    in_ring_next = '0;
                    rd_col_next  = '0;
                    rd_ring_next = '0;
                    c_row_next   = '0;
                    c_col_next   = '0;
                    c_ring_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg       <= '0;
            in_col_reg  <= '0;
            in_ring_reg <= '0;
            rd_col_reg  <= '0;
            rd_ring_reg <= '0;
            c_row_reg   <= '0;
            c_col_reg   <= '0;
            c_ring_reg  <= '0;
        end
        else
        begin
            p_reg       <= p_next;
            in_col_reg  <= in_col_next;
            in_ring_reg <= in_ring_next;
            rd_col_reg  <= rd_col_next;
            rd_ring_reg <= rd_ring_next;
            c_row_reg   <= c_row_next;
            c_col_reg   <= c_col_next;
            c_ring_reg  <= c_ring_next;
        end
    end

    // line store: blocking bits by column, classes by ring row and column
    logic [RING-1:0] blk_mem [MAX_WIDTH];
    logic [1:0]      cls_mem [RING][MAX_WIDTH];
    logic [RING-1:0] word_rd_reg;
    logic [1:0]      cls_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_mem[in_col_cur][in_ring_cur] <=
                (cell_in.cell_class == ogi_pkg::CLS_UNKNOWN) ||
                (cell_in.cell_class == ogi_pkg::CLS_WALL);
            cls_mem[in_ring_cur][in_col_cur] <= cell_in.cell_class;
        end
        if (adv)
        begin
            word_rd_reg <= blk_mem[rd_col_cur];
            cls_rd_reg  <= cls_mem[c_ring_cur][c_col_cur];
        end
    end

    // stage 1
    ogi_pkg::s1_ctl_t   s1_ctl_reg;
    logic [RING_W-1:0]  s1_base_reg;
    logic               s1_fwd_reg;
    logic [1:0]         s1_cls_reg;
    logic               s1_emit_reg, s1_last_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]   s1_col_reg;
    ogi_pkg::info_t     s1_info;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg.valid <= accept && !drop;
            s1_ctl_reg.push  <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_base_reg <= base;
            s1_fwd_reg  <= (r_eff_reg == '0);
            s1_cls_reg  <= cell_in.cell_class;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_row_reg  <= c_row_cur;
            s1_col_reg  <= c_col_cur;
        end
    end

    // with no lag the centre is the word being written: take it straight
    always_comb
    begin
        s1_info.emit    = s1_emit_reg;
        s1_info.last    = s1_last_reg;
        s1_info.row     = s1_row_reg;
        s1_info.out_col = ogi_pkg::OUT_COL_W'(s1_col_reg);
        s1_info.cls     = ogi_pkg::cls_t'(s1_fwd_reg ? s1_cls_reg : cls_rd_reg);
    end

    logic           s3_valid;
    ogi_pkg::info_t s3_info;
    logic [TAPS-1:0] s3_hit;

    ogi_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_ctl   (s1_ctl_reg),
        .s1_base  (s1_base_reg),
        .s1_word  (word_rd_reg),
        .s1_info  (s1_info),
        .s1_col   (s1_col_reg),
        .w_eff    (w_eff_reg),
        .h_eff    (h_eff_reg),
        .r_eff    (r_eff_reg),
        .disk     (disk_reg),
        .s3_valid (s3_valid),
        .s3_info  (s3_info),
        .s3_hit   (s3_hit)
    );

    // output register
    ogi_pkg::cls_t                out_class_reg;
    logic [ROW_W-1:0]             out_row_reg;
    logic [ogi_pkg::OUT_COL_W-1:0] out_col_reg;
    logic                         last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid && s3_info.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_class_reg <= ((s3_info.cls == ogi_pkg::CLS_FREE) && (|s3_hit))
                             ? ogi_pkg::CLS_INFLATED : s3_info.cls;
            out_row_reg   <= s3_info.row;
            out_col_reg   <= s3_info.out_col;
            last_reg      <= s3_info.last;
        end
    end

    assign cell_out.valid     = out_valid_reg;
    assign cell_out.out_class = out_class_reg;
    assign cell_out.out_row   = out_row_reg;
    assign cell_out.out_col   = out_col_reg;
    assign cell_out.last_cell = last_reg;

endmodule
